/* sv/yuvrgb_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// yuvrgb_pkg
// Shared types and fixed coefficients for the YUYV to RGB565 pair converter.
// ----------------------------------------------------------------------------
package yuvrgb_pkg;

   // Signed width that holds every channel sum before the shift by 8
   localparam int SUM_W = 18;

   localparam logic signed [SUM_W-1:0] LUMA_K    = SUM_W'(298);
   localparam logic signed [SUM_W-1:0] LUMA_OFS  = SUM_W'(16);
   localparam logic signed [SUM_W-1:0] RED_V_K   = SUM_W'(409);
   localparam logic signed [SUM_W-1:0] GRN_U_K   = SUM_W'(100);
   localparam logic signed [SUM_W-1:0] GRN_V_K   = SUM_W'(208);
   localparam logic signed [SUM_W-1:0] BLU_U_K   = SUM_W'(420);
   localparam logic signed [SUM_W-1:0] ROUND_K   = SUM_W'(128);
   localparam logic        [7:0]       CHROMA_OFS = 8'h80;
   localparam logic        [7:0]       CHAN_MAX   = 8'hff;

   // Chroma contributions shared by both lanes, rounding term folded in
   typedef struct packed {
      logic signed [SUM_W-1:0] red;
      logic signed [SUM_W-1:0] green;
      logic signed [SUM_W-1:0] blue;
   } chroma_terms_type;

endpackage
`default_nettype wire

/* sv/yuvrgb_chroma.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// yuvrgb_chroma
// Registers the U/V contributions to R, G and B once per pixel pair.
// ----------------------------------------------------------------------------
module yuvrgb_chroma (
   input  wire logic                         clock,
   input  wire logic [7:0]                   chroma_blue,
   input  wire logic [7:0]                   chroma_red,
   output yuvrgb_pkg::chroma_terms_type      terms
);

   logic signed [yuvrgb_pkg::SUM_W-1:0] d_ext;
   logic signed [yuvrgb_pkg::SUM_W-1:0] e_ext;
   yuvrgb_pkg::chroma_terms_type        terms_in;
   yuvrgb_pkg::chroma_terms_type        terms_ff;

   // Flipping the MSB turns the offset-128 sample into its signed value
   always_comb begin
      d_ext = yuvrgb_pkg::SUM_W'(signed'(chroma_blue ^ yuvrgb_pkg::CHROMA_OFS));
      e_ext = yuvrgb_pkg::SUM_W'(signed'(chroma_red ^ yuvrgb_pkg::CHROMA_OFS));
      terms_in.red   = e_ext * yuvrgb_pkg::RED_V_K + yuvrgb_pkg::ROUND_K;
      terms_in.green = yuvrgb_pkg::ROUND_K - d_ext * yuvrgb_pkg::GRN_U_K
                       - e_ext * yuvrgb_pkg::GRN_V_K;
      terms_in.blue  = d_ext * yuvrgb_pkg::BLU_U_K + yuvrgb_pkg::ROUND_K;
   end

   always_ff @(posedge clock) begin
      terms_ff <= terms_in;
   end

   assign terms = terms_ff;

endmodule
`default_nettype wire

/* sv/yuvrgb_lane.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// yuvrgb_lane
// One pixel: luma product, channel sums, clamp to 0..255 and RGB565 pack.
// ----------------------------------------------------------------------------
module yuvrgb_lane (
   input  wire logic                         clock,
   input  wire logic [7:0]                   luma,
   input  wire yuvrgb_pkg::chroma_terms_type terms,
   output logic [15:0]                       pixel
);

   logic signed [yuvrgb_pkg::SUM_W-1:0] c_ext;
   logic signed [yuvrgb_pkg::SUM_W-1:0] luma_term_in;
   logic signed [yuvrgb_pkg::SUM_W-1:0] luma_term_ff;
   logic signed [yuvrgb_pkg::SUM_W-1:0] sum_r;
   logic signed [yuvrgb_pkg::SUM_W-1:0] sum_g;
   logic signed [yuvrgb_pkg::SUM_W-1:0] sum_b;
   logic [7:0]                          chan_r;
   logic [7:0]                          chan_g;
   logic [7:0]                          chan_b;
   logic [15:0]                         pixel_in;
   logic [15:0]                         pixel_ff;

   function automatic logic [7:0] clamp_chan(input logic [yuvrgb_pkg::SUM_W-1:0] s);
      logic [7:0] res;
      // negative sums clamp to zero; bit 16 set means >> 8 exceeds 255
      if (s[yuvrgb_pkg::SUM_W-1]) begin
         res = '0;
      end else if (s[16]) begin
         res = yuvrgb_pkg::CHAN_MAX;
      end else begin
         res = s[15:8];
      end
      return res;
   endfunction

   always_comb begin
      c_ext = signed'(yuvrgb_pkg::SUM_W'(luma)) - yuvrgb_pkg::LUMA_OFS;
      luma_term_in = c_ext * yuvrgb_pkg::LUMA_K;
   end

   always_ff @(posedge clock) begin
      luma_term_ff <= luma_term_in;
   end

   always_comb begin
      sum_r    = luma_term_ff + terms.red;
      sum_g    = luma_term_ff + terms.green;
      sum_b    = luma_term_ff + terms.blue;
      chan_r   = clamp_chan(sum_r);
      chan_g   = clamp_chan(sum_g);
      chan_b   = clamp_chan(sum_b);
      pixel_in = {chan_r[7:3], chan_g[7:2], chan_b[7:3]};
   end

   always_ff @(posedge clock) begin
      pixel_ff <= pixel_in;
   end

   assign pixel = pixel_ff;

endmodule
`default_nettype wire

/* sv/yuvrgb_merge.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// yuvrgb_merge
// Combines the two lane pixels into four output bytes in the chosen order.
// ----------------------------------------------------------------------------
module yuvrgb_merge (
   input  wire logic        clock,
   input  wire logic        swap,
   input  wire logic [15:0] pixel_first,
   input  wire logic [15:0] pixel_second,
   output logic      [31:0] bytes
);

   logic [31:0] bytes_in;
   logic [31:0] bytes_ff;

   always_comb begin
      if (swap) begin
         bytes_in = {pixel_first[7:0], pixel_first[15:8],
                     pixel_second[7:0], pixel_second[15:8]};
      end else begin
         bytes_in = {pixel_first, pixel_second};
      end
   end

   always_ff @(posedge clock) begin
      bytes_ff <= bytes_in;
   end

   assign bytes = bytes_ff;

endmodule
`default_nettype wire

/* sv/yuv422_to_rgb565_pair.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// yuv422_to_rgb565_pair
// YUYV pixel pair to two RGB565 pixels, four bytes, with frame end marker.
//
//   channel   ports                          handshake
//   input     req_* fields, start            transfer when start && !busy
//   result    rsp_* fields                   rsp_strobe, one cycle, no stall
//   config    csr_wr_en, csr_wr_data         write on csr_wr_en
//
// The pipeline registers, in order: chroma and luma products, channel sums with clamp
// and pack in each lane, then the byte order merge register.
// One pixel pair is taken every cycle; busy stays low.
// Synchronous reset clears the valid pipeline and the byte order register.
// Results cannot be held off, so nothing stalls inside the pipeline.
// ----------------------------------------------------------------------------
module yuv422_to_rgb565_pair (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output logic            busy,
   input  wire logic [7:0] req_luma_first,
   input  wire logic [7:0] req_chroma_blue,
   input  wire logic [7:0] req_luma_second,
   input  wire logic [7:0] req_chroma_red,
   input  wire logic       req_frame_end_in,
   output logic            rsp_strobe,
   output logic [7:0]      rsp_out_byte0,
   output logic [7:0]      rsp_out_byte1,
   output logic [7:0]      rsp_out_byte2,
   output logic [7:0]      rsp_out_byte3,
   output logic            rsp_frame_end_out,
   input  wire logic       csr_wr_en,
   input  wire logic       csr_wr_data
);

   localparam int DEPTH = 3;

   yuvrgb_pkg::chroma_terms_type terms;
   logic [15:0]      pixel_first;
   logic [15:0]      pixel_second;
   logic [31:0]      bytes;
   logic             swap_ff;
   logic             swap_in;
   logic [DEPTH-1:0] valid_ff;
   logic [DEPTH-1:0] valid_in;
   logic [DEPTH-1:0] frame_end_ff;
   logic [DEPTH-1:0] frame_end_in;
   logic             accept;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_comb begin
      swap_in      = csr_wr_en ? csr_wr_data : swap_ff;
      valid_in     = {valid_ff[DEPTH-2:0], accept};
      frame_end_in = {frame_end_ff[DEPTH-2:0], req_frame_end_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         swap_ff  <= 1'b0;
         valid_ff <= '0;
      end else begin
         swap_ff  <= swap_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      frame_end_ff <= frame_end_in;
   end

   yuvrgb_chroma u_chroma (
      .clock       (clock),
      .chroma_blue (req_chroma_blue),
      .chroma_red  (req_chroma_red),
      .terms       (terms)
   );

   yuvrgb_lane u_lane_first (
      .clock (clock),
      .luma  (req_luma_first),
      .terms (terms),
      .pixel (pixel_first)
   );

   yuvrgb_lane u_lane_second (
      .clock (clock),
      .luma  (req_luma_second),
      .terms (terms),
      .pixel (pixel_second)
   );

   yuvrgb_merge u_merge (
      .clock        (clock),
      .swap         (swap_ff),
      .pixel_first  (pixel_first),
      .pixel_second (pixel_second),
      .bytes        (bytes)
   );

   assign rsp_strobe        = valid_ff[DEPTH-1];
   assign rsp_frame_end_out = frame_end_ff[DEPTH-1];
   assign rsp_out_byte0     = bytes[31:24];
   assign rsp_out_byte1     = bytes[23:16];
   assign rsp_out_byte2     = bytes[15:8];
   assign rsp_out_byte3     = bytes[7:0];

`ifndef SYNTHESIS
   a_transfer_yields_result: assert property (@(posedge clock) disable iff (reset)
      start |-> ##3 rsp_strobe)
      else $error("accepted pair produced no result");

   a_result_has_source: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start, 3))
      else $error("result without a transfer three cycles earlier");

   a_frame_end_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_frame_end_out == $past(req_frame_end_in, 3))
      else $error("frame end marker out of step with its pair");

   a_swap_mirrors_bytes: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && $stable(swap_ff) && $past(swap_ff) && $past(pixel_first) == 16'h00ff)
      |-> rsp_out_byte0 == 8'hff && rsp_out_byte1 == 8'h00)
      else $error("low byte first order not applied");
`endif

endmodule
`default_nettype wire
